FILE: rtl/core/tmr_pkg.sv
// Shared types and constants of the planar tile line renderer.
package tmr_pkg;

	localparam int SUM_W       = 22;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_LOG2   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_BEGIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_PALETTE = 2'd3;

	localparam logic [2:0]  COLS_LOG2_RESET = 3'd5;
	localparam logic [4:0]  PLANE_HI_OFFSET = 5'h10;
	localparam logic [2:0]  LAST_PIXEL_X    = 3'd7;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_MAP   = 2'd1,
		CMD_RAW   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic [2:0] line;
	} cmd_t;

	typedef struct packed {
		logic [3:0] pal;
		logic [7:0] p3;
		logic [7:0] p2;
		logic [7:0] p1;
		logic [7:0] p0;
	} em_load_t;

endpackage

FILE: rtl/core/tmr_stream_if.sv
// Handshake interfaces of the request and pixel channels.
interface tmr_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] mem_address;
	logic [7:0]  mem_data;
	logic [6:0]  tile_col;
	logic [8:0]  tile_row;
	logic [2:0]  tile_line;

	modport source (
		output valid, mode, mem_address, mem_data, tile_col, tile_row, tile_line,
		input  ready
	);
	modport sink (
		input  valid, mode, mem_address, mem_data, tile_col, tile_row, tile_line,
		output ready
	);
endinterface

interface tmr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic [2:0] pixel_x;
	logic       last;

	modport source (
		output valid, pixel, pixel_x, last,
		input  ready
	);
	modport sink (
		input  valid, pixel, pixel_x, last,
		output ready
	);
endinterface

FILE: rtl/core/tmr_front.sv
// Front end: accepts request words, classifies them and computes their start address.
module tmr_front #(
	parameter int AW = 16
) (
	tmr_in_if.sink                  req,
	input  logic                    map_mode,
	input  logic [2:0]              cols_log2,
	input  logic [15:0]             raw_begin,
	input  logic [3:0]              raw_palette,
	input  logic                    q_full,
	output logic                    push,
	output tmr_pkg::cmd_t           push_cmd,
	output logic [AW-1:0]           push_addr
);

	logic [15:0]              row_sh;
	logic [15:0]              tile_index;
	logic [tmr_pkg::SUM_W-1:0] write_sum;
	logic [tmr_pkg::SUM_W-1:0] map_sum;
	logic [tmr_pkg::SUM_W-1:0] raw_sum;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	assign row_sh     = 16'(req.tile_row) << cols_log2;
	assign tile_index = row_sh + 16'(req.tile_col);

	assign write_sum = tmr_pkg::SUM_W'(req.mem_address);
	assign map_sum   = tmr_pkg::SUM_W'({tile_index, 1'b0});
	assign raw_sum   = tmr_pkg::SUM_W'(raw_begin) + tmr_pkg::SUM_W'({tile_index, 5'b0})
		+ tmr_pkg::SUM_W'({req.tile_line, 1'b0});

	always_comb begin
		push_cmd.line = req.tile_line;
		if (!req.mode) begin
			push_cmd.kind = tmr_pkg::CMD_WRITE;
			push_cmd.data = req.mem_data;
			push_addr     = write_sum[AW-1:0];
		end else if (map_mode) begin
			push_cmd.kind = tmr_pkg::CMD_MAP;
			push_cmd.data = 8'd0;
			push_addr     = map_sum[AW-1:0];
		end else begin
			push_cmd.kind = tmr_pkg::CMD_RAW;
			push_cmd.data = {4'd0, raw_palette};
			push_addr     = raw_sum[AW-1:0];
		end
	end

endmodule

FILE: rtl/core/tmr_queue.sv
// Short command queue between the front end and the fetch engine.
module tmr_queue #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);

	localparam int PW = $clog2(tmr_pkg::QUEUE_DEPTH);

	logic [W-1:0]  slot_q [tmr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(tmr_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/core/tmr_fetch.sv
// Back end: video memory, byte writes and the map and plane byte fetch sequencer.
module tmr_fetch #(
	parameter int MEM_BYTES = 65536,
	parameter int AW        = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tmr_pkg::cmd_t      q_cmd,
	input  logic [AW-1:0]      q_addr,
	output logic               q_pop,
	input  logic               em_free,
	output logic               load_valid,
	output tmr_pkg::em_load_t  load_data
);

	typedef enum logic [4:0] {
		F_IDLE   = 5'b00001,
		F_MAP_LO = 5'b00010,
		F_MAP_HI = 5'b00100,
		F_PLANE  = 5'b01000,
		F_LAST   = 5'b10000
	} fetch_state_t;

	fetch_state_t state_q;
	logic [7:0]   mem_q [MEM_BYTES];
	logic [7:0]   rdata_q;
	logic [AW-1:0] map_q;
	logic [AW-1:0] base_q;
	logic [2:0]   line_q;
	logic [3:0]   pal_q;
	logic [7:0]   lo_q;
	logic [1:0]   pcnt_q;
	logic [7:0]   p0_q;
	logic [7:0]   p1_q;
	logic [7:0]   p2_q;

	logic          we;
	logic          re;
	logic [AW-1:0] raddr;
	logic [4:0]    plane_off;
	logic [tmr_pkg::SUM_W-1:0] plane_sum;
	logic [tmr_pkg::SUM_W-1:0] hi_sum;
	logic [tmr_pkg::SUM_W-1:0] map_base_sum;

	assign q_pop = (state_q == F_IDLE) && q_valid;
	assign we    = q_pop && (q_cmd.kind == tmr_pkg::CMD_WRITE);

	assign plane_off    = (pcnt_q[1] ? tmr_pkg::PLANE_HI_OFFSET : 5'd0) | {4'd0, pcnt_q[0]};
	assign plane_sum    = tmr_pkg::SUM_W'(base_q) + tmr_pkg::SUM_W'(plane_off);
	assign hi_sum       = tmr_pkg::SUM_W'(map_q) + tmr_pkg::SUM_W'(1);
	assign map_base_sum = tmr_pkg::SUM_W'({rdata_q[3:0], lo_q, 5'b0})
		+ tmr_pkg::SUM_W'({line_q, 1'b0});

	assign load_valid     = (state_q == F_LAST) && em_free;
	assign load_data.pal  = pal_q;
	assign load_data.p3   = rdata_q;
	assign load_data.p2   = p2_q;
	assign load_data.p1   = p1_q;
	assign load_data.p0   = p0_q;

	always_comb begin
		re    = 1'b0;
		raddr = q_addr;
		unique case (state_q) inside
			F_IDLE: begin
				re    = q_valid && (q_cmd.kind != tmr_pkg::CMD_WRITE);
				raddr = q_addr;
			end
			F_MAP_LO: begin
				re    = 1'b1;
				raddr = hi_sum[AW-1:0];
			end
			F_PLANE: begin
				re    = 1'b1;
				raddr = plane_sum[AW-1:0];
			end
			F_MAP_HI, F_LAST: begin
				re    = 1'b0;
				raddr = q_addr;
			end
			default: begin
				re    = 1'b0;
				raddr = q_addr;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[q_addr] <= q_cmd.data;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				map_q  <= q_addr;
				base_q <= q_addr;
				line_q <= q_cmd.line;
				pal_q  <= q_cmd.data[3:0];
			end
			F_MAP_LO: begin
				lo_q <= rdata_q;
			end
			F_MAP_HI: begin
				base_q <= map_base_sum[AW-1:0];
				pal_q  <= rdata_q[7:4];
			end
			F_PLANE: begin
				case (pcnt_q)
					2'd1:    p0_q <= rdata_q;
					2'd2:    p1_q <= rdata_q;
					2'd3:    p2_q <= rdata_q;
					default: p0_q <= p0_q;
				endcase
			end
			F_LAST: begin
				lo_q <= lo_q;
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pcnt_q  <= 2'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.kind)
							tmr_pkg::CMD_MAP: begin
								state_q <= F_MAP_LO;
							end
							tmr_pkg::CMD_RAW: begin
								state_q <= F_PLANE;
								pcnt_q  <= 2'd1;
							end
							default: begin
								state_q <= F_IDLE;
							end
						endcase
					end
				end
				F_MAP_LO: begin
					state_q <= F_MAP_HI;
				end
				F_MAP_HI: begin
					state_q <= F_PLANE;
					pcnt_q  <= 2'd0;
				end
				F_PLANE: begin
					pcnt_q <= pcnt_q + 2'd1;
					if (pcnt_q == 2'd3) begin
						state_q <= F_LAST;
					end
				end
				F_LAST: begin
					if (em_free) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/tmr_emit.sv
// Pixel emitter: turns four plane bytes into eight chunky pixels, one per word.
module tmr_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  tmr_pkg::em_load_t load_data,
	output logic              em_free,
	tmr_out_if.source         pix
);

	logic       busy_q;
	logic [2:0] x_q;
	logic [3:0] pal_q;
	logic [7:0] p0_q;
	logic [7:0] p1_q;
	logic [7:0] p2_q;
	logic [7:0] p3_q;
	logic       take;
	logic       at_last;

	assign at_last     = (x_q == tmr_pkg::LAST_PIXEL_X);
	assign take        = busy_q && pix.ready;
	assign em_free     = !busy_q || (take && at_last);

	assign pix.valid   = busy_q;
	assign pix.pixel   = {pal_q, p3_q[7], p2_q[7], p1_q[7], p0_q[7]};
	assign pix.pixel_x = x_q;
	assign pix.last    = at_last;

	always_ff @(posedge clk) begin
		if (load_valid) begin
			pal_q <= load_data.pal;
			p0_q  <= load_data.p0;
			p1_q  <= load_data.p1;
			p2_q  <= load_data.p2;
			p3_q  <= load_data.p3;
		end else if (take) begin
			p0_q <= {p0_q[6:0], 1'b0};
			p1_q <= {p1_q[6:0], 1'b0};
			p2_q <= {p2_q[6:0], 1'b0};
			p3_q <= {p3_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			x_q    <= 3'd0;
		end else if (load_valid) begin
			busy_q <= 1'b1;
			x_q    <= 3'd0;
		end else if (take) begin
			x_q <= x_q + 3'd1;
			if (at_last) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/tilemap_planar_tile_renderer.sv
// Top level of the planar tile line renderer.
//
// Request channel req: mode 0 words store mem_data at mem_address (modulo
// MEM_BYTES, which is a power of two), mode 1 words render one line of a tile.
// Pixel channel pix: each render gives eight words, pixel_x 0 to 7, last on the
// eighth, pixel holding the palette in the high nibble and the plane value below.
// The configuration port writes register cfg_index with cfg_data when cfg_we is
// high; the user must change registers only while no request is in flight, which
// the block itself does not enforce. Requests enter a four-entry queue and are
// executed in order, so a write is seen by every render accepted after it. A
// write leaves the back end idle. A render in map mode reads two map bytes and
// then four plane bytes through the single memory read port, in raw mode only
// the four plane bytes; the sequencer can fetch the next render while the emitter
// still sends the previous line. Reset empties the queue, idles the sequencer
// and sets the registers to their reset values; memory contents are undefined
// until written. When pix stalls, the emitter holds its word, the sequencer
// holds its finished line, the queue fills and req.ready falls.
module tilemap_planar_tile_renderer #(
	parameter int MEM_BYTES = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tmr_in_if.sink                         req,
	tmr_out_if.source                      pix,
	input  logic                           cfg_we,
	input  logic [tmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW      = $clog2(MEM_BYTES);
	localparam int ENTRY_W = $bits(tmr_pkg::cmd_t) + AW;

	logic        map_mode_q;
	logic [2:0]  cols_log2_q;
	logic [15:0] raw_begin_q;
	logic [3:0]  raw_palette_q;

	logic              push;
	tmr_pkg::cmd_t     push_cmd;
	logic [AW-1:0]     push_addr;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	logic [ENTRY_W-1:0] q_data;
	tmr_pkg::cmd_t     q_cmd;
	logic [AW-1:0]     q_addr;
	logic              em_free;
	logic              load_valid;
	tmr_pkg::em_load_t load_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q    <= 1'b0;
			cols_log2_q   <= tmr_pkg::COLS_LOG2_RESET;
			raw_begin_q   <= 16'd0;
			raw_palette_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmr_pkg::CFG_MAP_MODE:    map_mode_q    <= cfg_data[0];
				tmr_pkg::CFG_COLS_LOG2:   cols_log2_q   <= cfg_data[2:0];
				tmr_pkg::CFG_RAW_BEGIN:   raw_begin_q   <= cfg_data[15:0];
				tmr_pkg::CFG_RAW_PALETTE: raw_palette_q <= cfg_data[3:0];
				default:                  map_mode_q    <= map_mode_q;
			endcase
		end
	end

	tmr_front #(
		.AW(AW)
	) u_front (
		.req         (req),
		.map_mode    (map_mode_q),
		.cols_log2   (cols_log2_q),
		.raw_begin   (raw_begin_q),
		.raw_palette (raw_palette_q),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_addr   (push_addr)
	);

	tmr_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_addr}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	assign q_cmd  = q_data[ENTRY_W-1:AW];
	assign q_addr = q_data[AW-1:0];

	tmr_fetch #(
		.MEM_BYTES(MEM_BYTES),
		.AW       (AW)
	) u_fetch (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_addr     (q_addr),
		.q_pop      (q_pop),
		.em_free    (em_free),
		.load_valid (load_valid),
		.load_data  (load_data)
	);

	tmr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_data  (load_data),
		.em_free    (em_free),
		.pix        (pix)
	);

endmodule

FILE: rtl/core/tmr_checker.sv
// Port-level checks of the pixel channel, bound to the top level.
module tmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic [7:0] pix_pixel,
	input logic [2:0] pix_pixel_x,
	input logic       pix_last
);

	a_last_on_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (pix_last == (pix_pixel_x == 3'd7)))
		else $error("last does not match the eighth pixel");

	a_x_steps: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !pix_last |=>
			pix_valid && (pix_pixel_x == ($past(pix_pixel_x) + 3'd1)))
		else $error("pixel line broken or out of order");

	a_line_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix_last |=> !pix_valid || (pix_pixel_x == 3'd0))
		else $error("new line does not start at the leftmost pixel");

	a_palette_constant: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !pix_last |=> pix_pixel[7:4] == $past(pix_pixel[7:4]))
		else $error("palette changed within a line");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_pixel) && $stable(pix_pixel_x))
		else $error("stalled pixel word changed");

endmodule

bind tilemap_planar_tile_renderer tmr_checker u_tmr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pix.valid),
	.pix_ready   (pix.ready),
	.pix_pixel   (pix.pixel),
	.pix_pixel_x (pix.pixel_x),
	.pix_last    (pix.last)
);

FILE: bench/tb_tilemap_planar_tile_renderer.sv
// Self-checking testbench of the planar tile line renderer: directed table, then random phases.
module tb_tilemap_planar_tile_renderer;
	timeunit 1ns;
	timeprecision 1ps;

	import tmr_pkg::*;

	localparam int MEM_BYTES     = 65536;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 14;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	typedef enum logic [1:0] {
		ROW_REG,
		ROW_WRITE,
		ROW_RENDER
	} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [15:0]              value;
		logic [7:0]               data;
		logic [6:0]               col;
		logic [8:0]               row;
		logic [2:0]               line;
		bit                       known;
		logic [63:0]              pixels;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic [2:0] pixel_x;
		logic       last;
	} pixel_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tmr_in_if  req_if();
	tmr_out_if pix_if();

	tilemap_planar_tile_renderer #(
		.MEM_BYTES(MEM_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.pix      (pix_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	logic [7:0]  vram [MEM_BYTES];
	bit          vram_valid [MEM_BYTES];
	logic        map_mode_q;
	logic [2:0]  cols_log2_q;
	logic [15:0] raw_begin_q;
	logic [3:0]  raw_palette_q;

	pixel_word_t pending_pixels[$];
	stim_row_t   directed_rows[$];
	int          errors = 0;
	int          cycles = 0;
	int          burst_left = 0;
	int          ready_run = 0;
	logic        ready_level = 1'b1;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [15:0] wrap(input logic [31:0] a);
		return 16'(a % MEM_BYTES);
	endfunction

	function automatic logic [31:0] tile_index(input logic [6:0] col, input logic [8:0] row);
		return (32'(row) << cols_log2_q) + 32'(col);
	endfunction

	function automatic void line_source(input logic [6:0] col, input logic [8:0] row,
			input logic [2:0] line, output logic [31:0] base, output logic [3:0] pal);
		logic [31:0] entry_addr;
		logic [15:0] entry;
		if (map_mode_q) begin
			entry_addr = 2 * tile_index(col, row);
			entry = {vram[wrap(entry_addr + 1)], vram[wrap(entry_addr)]};
			base = 32'(entry[11:0]) * 32;
			pal = entry[15:12];
		end else begin
			base = 32'(raw_begin_q) + 32 * tile_index(col, row);
			pal = raw_palette_q;
		end
		base = base + 2 * 32'(line);
	endfunction

	function automatic logic [63:0] render_line(input logic [6:0] col, input logic [8:0] row,
			input logic [2:0] line);
		logic [31:0] base;
		logic [3:0]  pal;
		logic [7:0]  p0, p1, p2, p3;
		logic [63:0] pixels;
		line_source(col, row, line, base, pal);
		p0 = vram[wrap(base)];
		p1 = vram[wrap(base + 1)];
		p2 = vram[wrap(base + 32'(PLANE_HI_OFFSET))];
		p3 = vram[wrap(base + 32'(PLANE_HI_OFFSET) + 1)];
		for (int k = 0; k < 8; k++)
			pixels[63-8*k -: 8] = {pal, p3[7-k], p2[7-k], p1[7-k], p0[7-k]};
		return pixels;
	endfunction

	function automatic void row_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		stim_row_t r;
		r.kind = ROW_REG;
		r.idx = idx;
		r.value = value;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_write(input logic [15:0] addr, input logic [7:0] data);
		stim_row_t r;
		r.kind = ROW_WRITE;
		r.value = addr;
		r.data = data;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_render(input logic [6:0] col, input logic [8:0] row,
			input logic [2:0] line, input bit known, input logic [63:0] pixels);
		stim_row_t r;
		r.kind = ROW_RENDER;
		r.col = col;
		r.row = row;
		r.line = line;
		r.known = known;
		r.pixels = pixels;
		directed_rows.push_back(r);
	endfunction

	task automatic send_word(input logic mode, input logic [15:0] addr, input logic [7:0] data,
			input logic [6:0] col, input logic [8:0] row, input logic [2:0] line,
			input bit known, input logic [63:0] typed);
		int          gap;
		logic [63:0] pixels;
		pixel_word_t w;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.mode <= mode;
		if (mode == MODE_WRITE) begin
			req_if.mem_address <= addr;
			req_if.mem_data <= data;
			req_if.tile_col <= 7'($urandom);
			req_if.tile_row <= 9'($urandom);
			req_if.tile_line <= 3'($urandom);
		end else begin
			req_if.mem_address <= 16'($urandom);
			req_if.mem_data <= 8'($urandom);
			req_if.tile_col <= col;
			req_if.tile_row <= row;
			req_if.tile_line <= line;
		end
		do @(posedge clk); while (!req_if.ready);
		if (mode == MODE_WRITE) begin
			vram[wrap(32'(addr))] = data;
			vram_valid[wrap(32'(addr))] = 1'b1;
		end else begin
			pixels = known ? typed : render_line(col, row, line);
			for (int k = 0; k < 8; k++) begin
				w.pixel = pixels[63-8*k -: 8];
				w.pixel_x = 3'(k);
				w.last = (3'(k) == LAST_PIXEL_X);
				pending_pixels.push_back(w);
			end
		end
	endtask

	task automatic ensure_byte(input logic [15:0] addr);
		if (!vram_valid[addr])
			send_word(MODE_WRITE, addr, 8'($urandom), '0, '0, '0, 1'b0, '0);
	endtask

	// Every byte a render will read is written first, so no render touches unwritten memory.
	task automatic render_item(input logic [6:0] col, input logic [8:0] row,
			input logic [2:0] line, input bit known, input logic [63:0] typed);
		logic [31:0] base;
		logic [3:0]  pal;
		logic [31:0] entry_addr;
		if (map_mode_q) begin
			entry_addr = 2 * tile_index(col, row);
			ensure_byte(wrap(entry_addr));
			ensure_byte(wrap(entry_addr + 1));
		end
		line_source(col, row, line, base, pal);
		ensure_byte(wrap(base));
		ensure_byte(wrap(base + 1));
		ensure_byte(wrap(base + 32'(PLANE_HI_OFFSET)));
		ensure_byte(wrap(base + 32'(PLANE_HI_OFFSET) + 1));
		send_word(MODE_RENDER, '0, '0, col, row, line, known, typed);
	endtask

	task automatic drain_pipeline();
		req_if.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_MAP_MODE:    map_mode_q = value[0];
			CFG_COLS_LOG2:   cols_log2_q = value[2:0];
			CFG_RAW_BEGIN:   raw_begin_q = value;
			CFG_RAW_PALETTE: raw_palette_q = value[3:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] map_mode, input logic [15:0] cols_log2,
			input logic [15:0] raw_begin, input logic [15:0] raw_palette);
		drain_pipeline();
		set_reg(CFG_MAP_MODE, map_mode);
		set_reg(CFG_COLS_LOG2, cols_log2);
		set_reg(CFG_RAW_BEGIN, raw_begin);
		set_reg(CFG_RAW_PALETTE, raw_palette);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : pixel_sink
		pixel_word_t want;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t ns: expected no pixel word, got pixel %02h x %0d last %0b",
					$time, pix_if.pixel, pix_if.pixel_x, pix_if.last);
			end else begin
				want = pending_pixels.pop_front();
				if (want.pixel !== pix_if.pixel || want.pixel_x !== pix_if.pixel_x
						|| want.last !== pix_if.last) begin
					errors++;
					$display("%0t ns: expected pixel %02h x %0d last %0b, got pixel %02h x %0d last %0b",
						$time, want.pixel, want.pixel_x, want.last,
						pix_if.pixel, pix_if.pixel_x, pix_if.last);
				end
			end
		end
		if (ready_run == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					ready_level = 1'b1;
					ready_run = $urandom_range(1, 30);
				end
				4, 5, 6: begin
					ready_level = 1'($urandom_range(0, 1));
					ready_run = $urandom_range(1, 3);
				end
				7, 8: begin
					ready_level = 1'b0;
					ready_run = $urandom_range(1, 24);
				end
				default: begin
					ready_level = 1'b1;
					ready_run = $urandom_range(40, 120);
				end
			endcase
		end
		ready_run--;
		pix_if.ready <= ready_level;
	end

	initial begin : stimulus
		logic [6:0] col;
		logic [8:0] row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.mode = MODE_WRITE;
		req_if.mem_address = '0;
		req_if.mem_data = '0;
		req_if.tile_col = '0;
		req_if.tile_row = '0;
		req_if.tile_line = '0;
		pix_if.ready = 1'b0;
		map_mode_q = 1'b0;
		cols_log2_q = COLS_LOG2_RESET;
		raw_begin_q = '0;
		raw_palette_q = '0;

		// Registers at reset values: raw mode, palette zero, first character at zero.
		row_write(16'h0000, 8'hff);
		row_write(16'h0001, 8'hff);
		row_write(16'h0010, 8'hff);
		row_write(16'h0011, 8'hff);
		row_render(7'd0, 9'd0, 3'd0, 1'b1, 64'h0f0f_0f0f_0f0f_0f0f);
		row_write(16'h0000, 8'haa);
		row_write(16'h0001, 8'h00);
		row_write(16'h0010, 8'h00);
		row_write(16'h0011, 8'h00);
		row_render(7'd0, 9'd0, 3'd0, 1'b1, 64'h0100_0100_0100_0100);
		row_reg(CFG_RAW_PALETTE, 16'h000f);
		row_write(16'h0011, 8'hff);
		row_render(7'd0, 9'd0, 3'd0, 1'b1, 64'hf9f8_f9f8_f9f8_f9f8);
		// The plane bytes of the first character wrap past the top of memory.
		row_reg(CFG_RAW_BEGIN, 16'hffff);
		row_reg(CFG_COLS_LOG2, 16'h0000);
		row_render(7'd0, 9'd0, 3'd0, 1'b0, '0);
		row_reg(CFG_COLS_LOG2, 16'h0007);
		row_render(7'd127, 9'd511, 3'd7, 1'b0, '0);
		row_reg(CFG_MAP_MODE, 16'h0001);
		row_write(16'h0000, 8'hff);
		row_write(16'h0001, 8'hff);
		row_write(16'hffe0, 8'hff);
		row_write(16'hffe1, 8'hff);
		row_write(16'hfff0, 8'hff);
		row_write(16'hfff1, 8'hff);
		row_render(7'd0, 9'd0, 3'd0, 1'b1, 64'hffff_ffff_ffff_ffff);
		row_render(7'd127, 9'd511, 3'd7, 1'b0, '0);
		row_render(7'd0, 9'd0, 3'd7, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_REG: begin
					drain_pipeline();
					set_reg(directed_rows[i].idx, directed_rows[i].value);
					cfg_we <= 1'b0;
				end
				ROW_WRITE: send_word(MODE_WRITE, directed_rows[i].value, directed_rows[i].data,
					'0, '0, '0, 1'b0, '0);
				default: render_item(directed_rows[i].col, directed_rows[i].row,
					directed_rows[i].line, directed_rows[i].known, directed_rows[i].pixels);
			endcase
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
				1: configure(16'h0001, 16'h0007, 16'hffff, 16'h000f);
				2: configure(16'h0001, 16'h0000, 16'($urandom), 16'($urandom));
				3: configure(16'h0000, 16'h0007, 16'hffff, 16'h000f);
				default: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			repeat (PHASE_ITEMS) begin
				case ($urandom_range(0, 99)) inside
					[0:69]: begin
						// Small coordinates half the time so that written characters get reused.
						col = $urandom_range(0, 1) ? 7'($urandom_range(0, 3)) : 7'($urandom);
						row = $urandom_range(0, 1) ? 9'($urandom_range(0, 3)) : 9'($urandom);
						render_item(col, row, 3'($urandom), 1'b0, '0);
					end
					[70:96]: send_word(MODE_WRITE,
						$urandom_range(0, 1) ? 16'($urandom_range(0, 1023)) : 16'($urandom),
						8'($urandom), '0, '0, '0, 1'b0, '0);
					default: drain_pipeline();
				endcase
			end
		end

		drain_pipeline();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
